### src/dics_pkg.sv
// ============================================================================
// dics_pkg: shared types and constants of the discrete inverse-CDF sampler
// Field widths, table capacity, request and status codes, and the command
// record that travels from the front queue to the search engine.
// ============================================================================
package dics_pkg;

    // Table capacity and the widths that follow from it.
    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Fixed field widths.
    localparam int REQ_W    = 2;
    localparam int ENERGY_W = 24;
    localparam int WEIGHT_W = 16;
    localparam int RAND_W   = 32;
    localparam int CUM_W    = 24;
    localparam int BIN_W    = 8;
    localparam int STATUS_W = 2;
    localparam int PROD_W   = RAND_W + CUM_W;

    // Stream payload widths (tdata rounded up to whole bytes).
    localparam int S_DATA_W = ((ENERGY_W + WEIGHT_W + RAND_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((ENERGY_W + BIN_W + 7) / 8) * 8;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ENERGY_W-1:0] DEFAULT_ENERGY_RST = ENERGY_W'(1000);

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SEARCH,
        ST_ENERGY
    } eng_state_t;

    typedef struct packed {
        req_t                req;
        logic [ENERGY_W-1:0] energy;
        logic [WEIGHT_W-1:0] weight;
        logic [RAND_W-1:0]   rand_val;
    } cmd_t;

endpackage

### src/dics_front.sv
// ============================================================================
// dics_front: request intake and command queue
// Accepts requests from the input stream, decodes the request kind and holds
// them in a short queue until the engine takes them.
// ============================================================================
module dics_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dics_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [dics_pkg::REQ_W-1:0]    s_tuser,
    output logic                          q_valid,
    input  logic                          q_ready,
    output dics_pkg::cmd_t                q_cmd
);

    dics_pkg::cmd_t                    queue_reg [dics_pkg::QUEUE_DEPTH];
    logic [dics_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [dics_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [dics_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [dics_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [dics_pkg::QCNT_W-1:0]       fill_reg;
    logic [dics_pkg::QCNT_W-1:0]       fill_next;
    dics_pkg::cmd_t                    cmd_in;
    logic                              push;
    logic                              pop;

    // Classify the request kind and unpack the payload.
    always_comb
    begin
        unique case (s_tuser)
            2'd0:    cmd_in.req = dics_pkg::REQ_APPEND;
            2'd1:    cmd_in.req = dics_pkg::REQ_SAMPLE;
            2'd2:    cmd_in.req = dics_pkg::REQ_CLEAR;
            default: cmd_in.req = dics_pkg::REQ_NONE;
        endcase
        cmd_in.energy   = s_tdata[dics_pkg::ENERGY_W-1:0];
        cmd_in.weight   = s_tdata[dics_pkg::ENERGY_W +: dics_pkg::WEIGHT_W];
        cmd_in.rand_val = s_tdata[dics_pkg::ENERGY_W + dics_pkg::WEIGHT_W +: dics_pkg::RAND_W];
    end

    assign s_tready = (fill_reg != dics_pkg::QCNT_W'(dics_pkg::QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_cmd    = queue_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dics_pkg::QPTR_W'(dics_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dics_pkg::QPTR_W'(dics_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### src/dics_engine.sv
// ============================================================================
// dics_engine: spectrum table and inverse-CDF search
// Owns the energy and cumulative-weight memories, executes append, clear and
// sample commands, and holds the result in an output register.
// ============================================================================
module dics_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  dics_pkg::cmd_t                q_cmd,
    input  logic [dics_pkg::ENERGY_W-1:0] default_energy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dics_pkg::M_DATA_W-1:0] m_tdata,
    output logic [dics_pkg::STATUS_W-1:0] m_tuser
);

    logic [dics_pkg::ENERGY_W-1:0] energy_mem [dics_pkg::MAX_ENTRIES];
    logic [dics_pkg::CUM_W-1:0]    cum_mem    [dics_pkg::MAX_ENTRIES];
    logic [dics_pkg::ENERGY_W-1:0] energy_rdata_reg;
    logic [dics_pkg::CUM_W-1:0]    cum_rdata_reg;
    logic [dics_pkg::IDX_W-1:0]    energy_raddr;
    logic [dics_pkg::IDX_W-1:0]    cum_raddr;
    logic                          mem_we;
    logic [dics_pkg::CUM_W:0]      weight_sum;
    logic [dics_pkg::CUM_W-1:0]    sat_sum;

    dics_pkg::eng_state_t          state_reg;
    dics_pkg::eng_state_t          state_next;
    logic [dics_pkg::CNT_W-1:0]    count_reg;
    logic [dics_pkg::CNT_W-1:0]    count_next;
    logic [dics_pkg::CUM_W-1:0]    total_reg;
    logic [dics_pkg::CUM_W-1:0]    total_next;
    logic [dics_pkg::CNT_W-1:0]    lo_reg;
    logic [dics_pkg::CNT_W-1:0]    lo_next;
    logic [dics_pkg::CNT_W-1:0]    hi_reg;
    logic [dics_pkg::CNT_W-1:0]    hi_next;
    logic [dics_pkg::PROD_W-1:0]   prod_reg;
    logic [dics_pkg::PROD_W-1:0]   prod_next;
    logic [dics_pkg::CUM_W:0]      ceil_reg;
    logic [dics_pkg::CUM_W:0]      ceil_next;
    logic [dics_pkg::IDX_W-1:0]    idx_reg;
    logic [dics_pkg::IDX_W-1:0]    idx_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [dics_pkg::ENERGY_W-1:0] out_energy_reg;
    logic [dics_pkg::ENERGY_W-1:0] out_energy_next;
    logic [dics_pkg::BIN_W-1:0]    out_bin_reg;
    logic [dics_pkg::BIN_W-1:0]    out_bin_next;
    dics_pkg::status_t             out_status_reg;
    dics_pkg::status_t             out_status_next;

    logic                          out_free;
    logic                          take;
    logic                          table_empty;
    logic                          sample_go;
    logic [dics_pkg::CNT_W-1:0]    mid;
    logic [dics_pkg::CNT_W-1:0]    mid_step;
    logic                          go_left;
    logic [dics_pkg::CNT_W-1:0]    lo_step;
    logic [dics_pkg::CNT_W-1:0]    hi_step;
    logic                          search_done;
    logic [dics_pkg::CNT_W-1:0]    clamp_idx;

    assign out_free    = !out_valid_reg || m_tready;
    assign take        = (state_reg == dics_pkg::ST_IDLE) && q_valid && out_free;
    assign table_empty = (count_reg == '0) || (total_reg == '0);
    assign sample_go   = take && (q_cmd.req == dics_pkg::REQ_SAMPLE) && !table_empty;

    // One bisection step per cycle: the registered read of cum_mem[mid] is
    // compared against the target, and the next midpoint is addressed at once.
    assign mid         = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_left     = ({1'b0, cum_rdata_reg} >= ceil_reg);
    assign lo_step     = go_left ? lo_reg : mid + 1'b1;
    assign hi_step     = go_left ? mid : hi_reg;
    assign mid_step    = lo_step + ((hi_step - lo_step) >> 1);
    assign search_done = (lo_step >= hi_step);
    assign clamp_idx   = (lo_step >= count_reg) ? count_reg - 1'b1 : lo_step;

    assign weight_sum  = {1'b0, total_reg} + dics_pkg::CUM_W'(q_cmd.weight);
    assign sat_sum     = weight_sum[dics_pkg::CUM_W] ? '1 : weight_sum[dics_pkg::CUM_W-1:0];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dics_pkg::ST_IDLE:
            begin
                if (sample_go)
                begin
                    state_next = dics_pkg::ST_MUL;
                end
            end
            dics_pkg::ST_MUL:
            begin
                state_next = dics_pkg::ST_SEARCH;
            end
            dics_pkg::ST_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = dics_pkg::ST_ENERGY;
                end
            end
            dics_pkg::ST_ENERGY:
            begin
                if (out_free)
                begin
                    state_next = dics_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dics_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        q_ready         = take;
        mem_we          = 1'b0;
        count_next      = count_reg;
        total_next      = total_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        prod_next       = prod_reg;
        ceil_next       = ceil_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_energy_next = out_energy_reg;
        out_bin_next    = out_bin_reg;
        out_status_next = out_status_reg;
        cum_raddr       = mid[dics_pkg::IDX_W-1:0];
        energy_raddr    = idx_reg;

        unique case (state_reg)
            dics_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    out_valid_next  = 1'b1;
                    out_energy_next = '0;
                    out_bin_next    = '0;
                    out_status_next = dics_pkg::STAT_OK;
                    case (q_cmd.req)
                        dics_pkg::REQ_APPEND:
                        begin
                            if (count_reg == dics_pkg::CNT_W'(dics_pkg::MAX_ENTRIES))
                            begin
                                out_status_next = dics_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                total_next = sat_sum;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        dics_pkg::REQ_SAMPLE:
                        begin
                            if (table_empty)
                            begin
                                out_energy_next = default_energy;
                                out_status_next = dics_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // The result comes later, after the search.
                                out_valid_next = 1'b0;
                                prod_next = dics_pkg::PROD_W'(q_cmd.rand_val)
                                          * dics_pkg::PROD_W'(total_reg);
                                lo_next   = '0;
                                hi_next   = count_reg;
                            end
                        end
                        dics_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            dics_pkg::ST_MUL:
            begin
                // cum * 2^32 >= r * total  is  cum >= ceil((r * total) / 2^32).
                ceil_next = {1'b0, prod_reg[dics_pkg::PROD_W-1:dics_pkg::RAND_W]}
                          + (dics_pkg::CUM_W + 1)'(prod_reg[dics_pkg::RAND_W-1:0] != '0);
            end
            dics_pkg::ST_SEARCH:
            begin
                lo_next      = lo_step;
                hi_next      = hi_step;
                cum_raddr    = mid_step[dics_pkg::IDX_W-1:0];
                energy_raddr = clamp_idx[dics_pkg::IDX_W-1:0];
                if (search_done)
                begin
                    idx_next = clamp_idx[dics_pkg::IDX_W-1:0];
                end
            end
            dics_pkg::ST_ENERGY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_energy_next = energy_rdata_reg;
                    out_bin_next    = dics_pkg::BIN_W'(idx_reg);
                    out_status_next = dics_pkg::STAT_OK;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dics_pkg::ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        prod_reg       <= prod_next;
        ceil_reg       <= ceil_next;
        idx_reg        <= idx_next;
        out_energy_reg <= out_energy_next;
        out_bin_reg    <= out_bin_next;
        out_status_reg <= out_status_next;
    end

    // Table memories: one write port, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            energy_mem[count_reg[dics_pkg::IDX_W-1:0]] <= q_cmd.energy;
            cum_mem[count_reg[dics_pkg::IDX_W-1:0]]    <= sat_sum;
        end
        energy_rdata_reg <= energy_mem[energy_raddr];
        cum_rdata_reg    <= cum_mem[cum_raddr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bin_reg, out_energy_reg};
    assign m_tuser  = out_status_reg;

endmodule

### src/discrete_inverse_cdf_sampler_top.sv
// ============================================================================
// discrete_inverse_cdf_sampler_top: discrete inverse-transform sampler
// Loads an energy spectrum bin by bin and draws energies from it by an exact
// integer search of the cumulative weights.
// ============================================================================
// Each request on the input stream is an append (store one energy bin and add
// its weight to the saturating 24-bit running total), a sample (pick the first
// bin whose cumulative weight times 2^32 is at least r times the total), or a
// clear; every request answers with exactly one result on the output stream.
// Appends, clears and unknown requests are answered as the engine takes them.
// A sample is taken while r * total is formed; the engine then rounds the
// target, runs one bisection step per cycle over the stored bins (at most
// floor(log2(n)) + 1 steps for n bins, so 9 at the full 256), and moves the
// fetched energy into the output register once it is free. The length of a
// sample is set by the bisection loop over the cumulative-weight memory, which
// has one registered read port. A two-entry queue in front of the engine
// keeps the input open while a search runs. The output register holds a
// finished result until the receiver takes it; the engine takes its next
// request only once that register is empty or being read in the same cycle.
// An empty or weightless table returns the configured default energy with the
// empty status; an append to a full table is dropped with the full status.
// The default energy register may be written only while the block is idle.
module discrete_inverse_cdf_sampler_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, from bit 0: entry_energy[23:0], entry_weight[15:0],
    // random_fraction[31:0]
    input  logic [dics_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [dics_pkg::REQ_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, from bit 0: sampled_energy[23:0], bin_index[7:0]
    output logic [dics_pkg::M_DATA_W-1:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [dics_pkg::STATUS_W-1:0] m_tuser,
    input  logic                          cfg_we,
    input  logic [dics_pkg::ENERGY_W-1:0] cfg_wdata
);

    logic [dics_pkg::ENERGY_W-1:0] default_energy_reg;
    logic [dics_pkg::ENERGY_W-1:0] default_energy_next;
    logic                          q_valid;
    logic                          q_ready;
    dics_pkg::cmd_t                q_cmd;

    // Default energy register, written directly by the configuration port.
    assign default_energy_next = cfg_we ? cfg_wdata : default_energy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_energy_reg <= dics_pkg::DEFAULT_ENERGY_RST;
        end
        else
        begin
            default_energy_reg <= default_energy_next;
        end
    end

    // Front: takes requests, decodes their kind and queues them.
    dics_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    // Back: owns the spectrum tables and runs the search.
    dics_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_cmd          (q_cmd),
        .default_energy (default_energy_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the discrete inverse-CDF energy sampler
// Streams append, sample, clear and unknown requests into the sampler, predicts
// every result from an independent model of the spectrum table, and compares
// each returned result field by field while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dics_pkg::*;

    // One result as the sampler returns it.
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [BIN_W-1:0]    bin;
        status_t             status;
    } draw_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_we;
    logic [ENERGY_W-1:0]   cfg_wdata;

    // Predicted spectrum state, kept in step with every accepted request.
    logic [ENERGY_W-1:0]   spec_energy [MAX_ENTRIES];
    logic [CUM_W-1:0]      spec_cum    [MAX_ENTRIES];
    logic [CNT_W-1:0]      bin_count;
    logic [CUM_W-1:0]      weight_total;
    logic [ENERGY_W-1:0]   dflt_energy;

    // Results predicted but not yet returned, oldest first.
    draw_t                 pending_draws [$];

    int                    mismatch_count = 0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    hold_cycles    = 0;
    int                    fill_target    = 1;

    discrete_inverse_cdf_sampler_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one accepted request to the predicted table and returns the
    // result the sampler must give for it. The chosen bin is the lowest one
    // whose cumulative weight times 2^32 reaches r times the total weight;
    // the table is monotonic, so a downward scan that keeps the last hit finds
    // it. When nothing qualifies the last stored bin is taken.
    function automatic draw_t predict_draw(input cmd_t c);
        draw_t           d;
        logic [CUM_W:0]  sum;
        logic [63:0]     target;
        int              pick;
        d = '{energy: '0, bin: '0, status: STAT_OK};
        case (c.req)
            REQ_APPEND:
            begin
                if (bin_count >= MAX_ENTRIES)
                begin
                    d.status = STAT_FULL;
                end
                else
                begin
                    sum = {1'b0, weight_total} + (CUM_W + 1)'(c.weight);
                    if (sum[CUM_W])
                    begin
                        sum = {1'b0, {CUM_W{1'b1}}};
                    end
                    weight_total                       = sum[CUM_W-1:0];
                    spec_energy[bin_count[IDX_W-1:0]] = c.energy;
                    spec_cum[bin_count[IDX_W-1:0]]    = sum[CUM_W-1:0];
                    bin_count                          = bin_count + 1'b1;
                end
            end
            REQ_SAMPLE:
            begin
                if (bin_count == 0 || weight_total == 0)
                begin
                    d.energy = dflt_energy;
                    d.status = STAT_EMPTY;
                end
                else
                begin
                    target = 64'(c.rand_val) * 64'(weight_total);
                    pick   = int'(bin_count) - 1;
                    for (int i = int'(bin_count) - 1; i >= 0; i--)
                    begin
                        if (64'({spec_cum[i], 32'd0}) >= target)
                        begin
                            pick = i;
                        end
                    end
                    d.energy = spec_energy[pick];
                    d.bin    = BIN_W'(pick);
                end
            end
            REQ_CLEAR:
            begin
                bin_count    = '0;
                weight_total = '0;
            end
            default:
            begin
                // Unknown requests change nothing and answer all zero.
            end
        endcase
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver, result checker and receiver
    // ------------------------------------------------------------------------

    // Offers one request, waits for the handshake and records the result it
    // must produce. An idle gap of random length may come first; when none
    // does, tvalid simply stays high into the next request.
    task automatic send_req(input req_t req, input logic [ENERGY_W-1:0] energy,
                            input logic [WEIGHT_W-1:0] weight,
                            input logic [RAND_W-1:0] rfrac);
        cmd_t c;
        c = '{req: req, energy: energy, weight: weight, rand_val: rfrac};
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.rand_val, c.weight, c.energy};
        s_tuser  <= c.req;
        do
            @(posedge clk);
        while (!s_tready);
        pending_draws = {pending_draws, predict_draw(c)};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Every result taken off the output stream is matched against the oldest
    // prediction.
    always @(posedge clk)
    begin
        draw_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_draws.size() == 0)
            begin
                report_mismatch("result with nothing pending", '0, 32'(m_tdata));
            end
            else
            begin
                want = pending_draws.pop_front();
                if (m_tdata[ENERGY_W-1:0] !== want.energy)
                    report_mismatch("sampled_energy", 32'(want.energy),
                                    32'(m_tdata[ENERGY_W-1:0]));
                if (m_tdata[ENERGY_W +: BIN_W] !== want.bin)
                    report_mismatch("bin_index", 32'(want.bin),
                                    32'(m_tdata[ENERGY_W +: BIN_W]));
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_tuser));
            end
        end
    end

    // The receiver stalls at random, or holds off completely while a hold-off
    // count is running.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Stops offering requests and waits until every predicted result is back,
    // so that the block is idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the default energy while the block is idle.
    task automatic write_default(input logic [ENERGY_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        dflt_energy  = value;
    endtask

    // ------------------------------------------------------------------------
    // Random field values, with the extremes weighted up
    // ------------------------------------------------------------------------

    function automatic logic [ENERGY_W-1:0] rand_energy();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        return ENERGY_W'($urandom);
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return '0;
        if (roll < 30)
            return '1;
        if (roll < 50)
            return WEIGHT_W'($urandom_range(1, 15));
        return WEIGHT_W'($urandom);
    endfunction

    function automatic logic [RAND_W-1:0] rand_fraction();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return '1;
        return $urandom;
    endfunction

    // Table size the random stream builds up to before it mostly samples:
    // usually a handful of bins, sometimes more, rarely the full capacity.
    function automatic int pick_fill_target();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 87)
            return $urandom_range(1, 12);
        if (roll < 97)
            return $urandom_range(13, 64);
        return MAX_ENTRIES + 4;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty and weightless tables, the unknown request, zero-weight bins and
    // the extremes of every field.
    task automatic test_special_cases();
        send_req(REQ_SAMPLE, '0, '0, '1);
        send_req(REQ_NONE, '1, '1, '1);
        send_req(REQ_CLEAR, '1, '1, '1);
        send_req(REQ_SAMPLE, '1, '1, '0);
        // A bin with weight zero leaves the table weightless.
        send_req(REQ_APPEND, '0, '0, '1);
        send_req(REQ_SAMPLE, '0, '0, '1);
        send_req(REQ_SAMPLE, '0, '0, '0);
        send_req(REQ_APPEND, '1, '1, '0);
        // With weight present, r = 0 still lands on the zero-weight first bin.
        send_req(REQ_SAMPLE, '0, '0, '0);
        send_req(REQ_SAMPLE, '0, '0, 32'd1);
        send_req(REQ_SAMPLE, '0, '0, '1);
        send_req(REQ_APPEND, 24'h123456, 16'd1, '0);
        send_req(REQ_SAMPLE, '0, '0, '1);
        send_req(REQ_SAMPLE, '0, '0, 32'hFFFF_0000);
        send_req(REQ_SAMPLE, '0, '0, 32'h8000_0000);
        send_req(REQ_NONE, '0, '0, '0);
        send_req(REQ_SAMPLE, '1, '1, 32'h0001_0000);
        send_req(REQ_CLEAR, '0, '0, '0);
        send_req(REQ_SAMPLE, '0, '0, 32'h5555_5555);
    endtask

    // The default energy is visible only on an empty or weightless table; it is
    // written at both ends of its range and once at random.
    task automatic test_default_energy();
        send_req(REQ_CLEAR, '0, '0, '0);
        write_default('0);
        send_req(REQ_SAMPLE, '0, '0, 32'h1234_5678);
        write_default('1);
        send_req(REQ_SAMPLE, '0, '0, '0);
        send_req(REQ_NONE, '0, '0, '0);
        write_default(ENERGY_W'($urandom));
        send_req(REQ_SAMPLE, '0, '0, '1);
    endtask

    // Fills all bins, pushes appends past the end, samples the full table at
    // the ends of the fraction range and at random, and empties it again.
    task automatic test_full_table();
        send_req(REQ_CLEAR, '0, '0, '0);
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            send_req(REQ_APPEND, rand_energy(),
                     ($urandom_range(0, 3) == 0) ? rand_weight() : '1, '0);
        end
        repeat (3) send_req(REQ_APPEND, rand_energy(), rand_weight(), '1);
        send_req(REQ_SAMPLE, '0, '0, '0);
        send_req(REQ_SAMPLE, '0, '0, '1);
        repeat (12) send_req(REQ_SAMPLE, '0, '0, rand_fraction());
        send_req(REQ_CLEAR, '0, '0, '0);
        send_req(REQ_SAMPLE, '0, '0, '1);
    endtask

    // Mostly well-formed traffic: the table grows to a chosen size and is
    // then sampled, with clears, stray appends and unknown requests mixed in.
    task automatic test_random_traffic(input int count);
        int roll;
        send_req(REQ_CLEAR, rand_energy(), rand_weight(), rand_fraction());
        fill_target = pick_fill_target();
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                send_req(REQ_NONE, rand_energy(), rand_weight(), rand_fraction());
            end
            else if (roll < 5)
            begin
                send_req(REQ_CLEAR, rand_energy(), rand_weight(), rand_fraction());
                fill_target = pick_fill_target();
            end
            else if ((bin_count < fill_target && roll < 75) || roll < 10)
            begin
                send_req(REQ_APPEND, rand_energy(), rand_weight(), rand_fraction());
            end
            else
            begin
                send_req(REQ_SAMPLE, rand_energy(), rand_weight(), rand_fraction());
            end
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the sampler fills its queue and output register and closes its input.
    task automatic test_backpressure();
        send_req(REQ_CLEAR, '0, '0, '0);
        repeat (6) send_req(REQ_APPEND, rand_energy(), rand_weight(), '0);
        hold_cycles = 300;
        repeat (30) send_req(REQ_SAMPLE, '0, '0, rand_fraction());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        bin_count    = '0;
        weight_total = '0;
        dflt_energy  = DEFAULT_ENERGY_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rare sender gaps, a receiver that stalls most of the time.
        send_idle_pct  = 7;
        recv_stall_pct = 76;
        test_special_cases();
        test_default_energy();
        test_full_table();
        test_random_traffic(420);

        // Frequent sender gaps, a receiver that rarely stalls.
        write_default(ENERGY_W'($urandom));
        send_idle_pct  = 76;
        recv_stall_pct = 7;
        test_random_traffic(420);

        // No idling at all, apart from one long hold-off on the output.
        write_default('1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();
        write_default(ENERGY_W'($urandom));
        test_random_traffic(420);

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_draws.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
